[sv/uvs_pkg.sv]
// Package: shared types, constants and tables for the UV sphere vertex generator.
`default_nettype none
package uvs_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] REG_HORIZONTAL = 2'd0;
  localparam logic [1:0] REG_VERTICAL   = 2'd1;

  typedef logic [10:0] seg_t;

  typedef struct packed {
    logic [10:0] column;
    logic [10:0] row;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               quad_valid;
    logic [20:0]        idx_top_left;
    logic [20:0]        idx_bottom_left;
    logic [20:0]        idx_top_right;
    logic [20:0]        idx_bottom_right;
    logic               out_of_range;
  } out_item_t;

  // Classified grid point handed from front to back.
  typedef struct packed {
    logic [10:0] column;
    logic [10:0] row;
    logic [10:0] h;
    logic [10:0] v;
    logic        quad;
    logic        oor;
  } job_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};
    return t[i];
  endfunction

endpackage
`default_nettype wire

[sv/uvs_if.sv]
// Interfaces: valid/ready channels for grid points, vertices and register writes.
`default_nettype none
interface uvs_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] column;
  logic [10:0] row;
  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic               quad_valid;
  logic [20:0]        idx_top_left;
  logic [20:0]        idx_bottom_left;
  logic [20:0]        idx_top_right;
  logic [20:0]        idx_bottom_right;
  logic               out_of_range;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, quad_valid,
                  idx_top_left, idx_bottom_left, idx_top_right, idx_bottom_right,
                  out_of_range, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, quad_valid,
                  idx_top_left, idx_bottom_left, idx_top_right, idx_bottom_right,
                  out_of_range, output ready);
endinterface

interface uvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/uv_sphere_vertex_generator_top.sv]
// Top level: UV sphere vertex generator, front classifier plus pipelined back end.
//
//  channel | dir | transfer when
//  in_     | in  | in_ch.valid & in_ch.ready  (column, row)
//  out_    | out | out_ch.valid & out_ch.ready (vertex)
//  cfg_    | in  | cfg_ch.valid & cfg_ch.ready (index, data), always ready
//
// One vertex per clock sustained while out_ch.ready stays high. In to out passes
// through the job queue, 28 divider stages, 30 CORDIC stages, the CORDIC output
// and multiply registers, and the output register.
// rst_n is synchronous: segment counts return to 32 and 16, all queues empty.
// A stall at out_ freezes the whole back pipeline once a vertex waits at its tail;
// the queue takes up to two more points before in_ch.ready drops.
`default_nettype none
module uv_sphere_vertex_generator_top #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int ANGLE_BITS   = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  uvs_in_if.sink    in_ch,
  uvs_out_if.source out_ch,
  uvs_cfg_if.sink   cfg_ch
);
  import uvs_pkg::*;

  job_t job;
  logic job_valid, job_take;

  uvs_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk, .rst_n, .in_ch, .cfg_ch, .job, .job_valid, .job_take);

  uvs_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk, .rst_n, .job, .job_valid, .job_take, .out_ch);

  // a job is never taken from an empty queue
  a_take: assert property (@(posedge clk) disable iff (!rst_n) job_take |-> job_valid)
    else $error("job taken from empty queue");
  // held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pos_x))
    else $error("stalled result changed");
  // a quad flag and out-of-range flag never coincide
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.quad_valid && out_ch.out_of_range))
    else $error("quad and out of range both set");
endmodule
`default_nettype wire

[sv/uvs_divider.sv]
// Pipelined restoring divider: one quotient bit per stage.
`default_nettype none
module uvs_divider #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 11,
  parameter int TAG_W = 1
) (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [TAG_W-1:0] tag_in,
  output logic      [NUM_W-1:0] quo,
  output logic      [TAG_W-1:0] tag_out
);
  // stage k holds partial remainder, remaining numerator bits and quotient bits
  logic [DEN_W:0]   rem_r [NUM_W+1];
  logic [NUM_W-1:0] sh_r  [NUM_W+1];
  logic [DEN_W-1:0] den_r [NUM_W+1];
  logic [TAG_W-1:0] tag_r [NUM_W+1];

  always_comb begin
    rem_r[0] = '0;
    sh_r[0]  = num;
    den_r[0] = den;
    tag_r[0] = tag_in;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_st
    logic [DEN_W+1:0] trial;
    logic [DEN_W:0]   rem_nxt;
    logic [NUM_W-1:0] sh_nxt;
    always_comb begin
      trial   = {rem_r[k], sh_r[k][NUM_W-1]};
      sh_nxt  = {sh_r[k][NUM_W-2:0], 1'b0};
      rem_nxt = trial[DEN_W:0];
      if (trial >= {2'b00, den_r[k]}) begin
        rem_nxt   = (DEN_W+1)'(trial - {2'b00, den_r[k]});
        sh_nxt[0] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= rem_nxt;
        sh_r[k+1]  <= sh_nxt;
        den_r[k+1] <= den_r[k];
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  assign quo     = sh_r[NUM_W];
  assign tag_out = tag_r[NUM_W];
endmodule
`default_nettype wire

[sv/uvs_cordic.sv]
// Pipelined CORDIC: sine and cosine in signed Q4.30 of a 32-bit turn fraction (Q0.32).
`default_nettype none
module uvs_cordic (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic [31:0]        angle,
  output logic signed [33:0]      sin_o,
  output logic signed [33:0]      cos_o
);
  import uvs_pkg::*;

  logic signed [33:0] x_r [CORDIC_STEPS+1];
  logic signed [33:0] y_r [CORDIC_STEPS+1];
  logic signed [33:0] z_r [CORDIC_STEPS+1];
  logic [1:0]         q_r [CORDIC_STEPS+1];

  always_comb begin
    x_r[0] = CORDIC_GAIN;
    y_r[0] = '0;
    z_r[0] = $signed({4'b0000, angle[29:0]});
    q_r[0] = angle[31:30];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_st
    logic signed [33:0] at;
    assign at = $signed({2'b00, atan_turn(i)});
    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + at;
        end
      end
    end
  end

  always_comb begin
    case (q_r[CORDIC_STEPS])
      2'd0:    begin sin_o = y_r[CORDIC_STEPS];  cos_o = x_r[CORDIC_STEPS];  end
      2'd1:    begin sin_o = x_r[CORDIC_STEPS];  cos_o = -y_r[CORDIC_STEPS]; end
      2'd2:    begin sin_o = -y_r[CORDIC_STEPS]; cos_o = -x_r[CORDIC_STEPS]; end
      default: begin sin_o = -x_r[CORDIC_STEPS]; cos_o = y_r[CORDIC_STEPS];  end
    endcase
  end
endmodule
`default_nettype wire

[sv/uvs_front.sv]
// Front end: register file, segment clamping, classification and job queue.
`default_nettype none
module uvs_front #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  uvs_in_if.sink             in_ch,
  uvs_cfg_if.sink            cfg_ch,
  output uvs_pkg::job_t      job,
  output logic               job_valid,
  input  wire logic          job_take
);
  import uvs_pkg::*;

  localparam int QD = 2;

  seg_t hreg_r, vreg_r, h_c, v_c;
  job_t q_r [QD];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  job_t nj;
  logic push;

  function automatic seg_t clamp(input seg_t s);
    if (s == '0) return 11'd1;
    if ({21'd0, s} > MAX_SEGMENTS) return seg_t'(MAX_SEGMENTS);
    return s;
  endfunction

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hreg_r <= 11'd32;
      vreg_r <= 11'd16;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_HORIZONTAL) hreg_r <= cfg_ch.data;
      else if (cfg_ch.index == REG_VERTICAL) vreg_r <= cfg_ch.data;
    end
  end

  always_comb begin
    h_c = clamp(hreg_r);
    v_c = clamp(vreg_r);
    nj.column = in_ch.column;
    nj.row    = in_ch.row;
    nj.h      = h_c;
    nj.v      = v_c;
    nj.quad   = (in_ch.column < h_c) && (in_ch.row < v_c);
    nj.oor    = (in_ch.column > h_c) || (in_ch.row > v_c);
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign job_valid   = (cnt_r != 2'd0);
  assign job         = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !job_take) cnt_nxt = cnt_r + 2'd1;
    else if (!push && job_take) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (job_take) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= nj;
  end
endmodule
`default_nettype wire

[sv/uvs_back.sv]
// Back end: divider, CORDIC, product and index pipeline with output skid buffer.
`default_nettype none
module uvs_back #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  uvs_pkg::job_t      job,
  input  wire logic          job_valid,
  output logic               job_take,
  uvs_out_if.source          out_ch
);
  import uvs_pkg::*;

  // 11-bit index shifted by the wider of 16 and ANGLE_BITS, plus one quotient bit
  localparam int NW   = 12 + ((ANGLE_BITS > 16) ? ANGLE_BITS : 16);
  localparam int DLAT = NW;
  localparam int CLAT = CORDIC_STEPS;
  localparam int LAT  = DLAT + CLAT + 2;

  // Pipeline advances whenever the skid stage has room or the pipeline tail is empty.
  logic adv;
  logic [LAT-1:0] vld_r;
  out_item_t skid_r;
  logic      skid_vld_r;

  // Side data carried alongside the divider.
  typedef struct packed {
    logic [16:0] tu;
    logic [16:0] tv;
    logic        quad;
    logic [20:0] tl;
    logic [20:0] bl;
    logic        oor;
  } side_t;

  logic [NW-1:0] nth, nph, ntu, ntv, qth, qph, qtu, qtv;
  logic [21:0] tl_c, bl_c;
  side_t side_in, side_d, side_c [CLAT+3];
  logic [31:0] a_th, a_ph;
  logic [16:0] tu_s, tv_s;
  logic signed [33:0] sp, cp, st, ct;
  // CORDIC magnitudes stay below 2^31, so 32-bit operands feed the multipliers
  logic signed [31:0] sp_r, st_r, ct_r;
  logic signed [33:0] cp_r;
  logic signed [63:0] px_r, pz_r;
  logic signed [33:0] cp2_r;
  logic signed [68:0] pxr, pzr;
  logic signed [34:0] pyr;
  logic signed [23:0] px_s, pz_s;
  logic signed [19:0] py_s;
  out_item_t res;

  assign adv      = !skid_vld_r || out_ch.ready || !vld_r[LAT-1];
  assign job_take = job_valid && adv;

  always_comb begin
    nth = NW'({{(NW-11){1'b0}}, job.column} << ANGLE_BITS) + NW'(job.h >> 1);
    nph = NW'({{(NW-11){1'b0}}, job.row} << (ANGLE_BITS - 1)) + NW'(job.v >> 1);
    ntu = NW'({{(NW-11){1'b0}}, job.column} << 16) + NW'(job.h >> 1);
    ntv = NW'({{(NW-11){1'b0}}, job.row} << 16) + NW'(job.v >> 1);
    tl_c = 22'(job.row * ({11'd0, job.h} + 22'd1)) + {11'd0, job.column};
    bl_c = tl_c + 22'({11'd0, job.h}) + 22'd1;
    side_in.tu = '0;
    side_in.tv = '0;
    side_in.quad = job.quad;
    side_in.tl = job.quad ? tl_c[20:0] : '0;
    side_in.bl = job.quad ? bl_c[20:0] : '0;
    side_in.oor = job.oor;
  end

  uvs_divider #(.NUM_W(NW), .DEN_W(11), .TAG_W($bits(side_t))) u_div_th (
    .clk, .adv, .num(nth), .den(job.h), .tag_in(side_in), .quo(qth), .tag_out(side_d));
  uvs_divider #(.NUM_W(NW), .DEN_W(11), .TAG_W(1)) u_div_ph (
    .clk, .adv, .num(nph), .den(job.v), .tag_in(1'b0), .quo(qph), .tag_out());
  uvs_divider #(.NUM_W(NW), .DEN_W(11), .TAG_W(1)) u_div_tu (
    .clk, .adv, .num(ntu), .den(job.h), .tag_in(1'b0), .quo(qtu), .tag_out());
  uvs_divider #(.NUM_W(NW), .DEN_W(11), .TAG_W(1)) u_div_tv (
    .clk, .adv, .num(ntv), .den(job.v), .tag_in(1'b0), .quo(qtv), .tag_out());

  assign a_th = {qth[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
  assign a_ph = {qph[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
  assign tu_s = (qtu > NW'(65536)) ? 17'd65536 : qtu[16:0];
  assign tv_s = (qtv > NW'(65536)) ? 17'd65536 : qtv[16:0];

  uvs_cordic u_cor_ph (.clk, .adv, .angle(a_ph), .sin_o(sp), .cos_o(cp));
  uvs_cordic u_cor_th (.clk, .adv, .angle(a_th), .sin_o(st), .cos_o(ct));

  always_comb begin
    side_c[0]    = side_d;
    side_c[0].tu = tu_s;
    side_c[0].tv = tv_s;
  end
  for (genvar k = 0; k < CLAT + 2; k++) begin : g_sd
    always_ff @(posedge clk) if (adv) side_c[k+1] <= side_c[k];
  end

  // CORDIC outputs registered, then one multiply stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      sp_r <= sp[31:0]; cp_r <= cp; st_r <= st[31:0]; ct_r <= ct[31:0];
      px_r <= sp_r * ct_r;
      pz_r <= sp_r * st_r;
      cp2_r <= cp_r;
    end
  end

  always_comb begin
    pxr  = (69'(px_r) + (69'sd1 <<< 44)) >>> 45;
    pzr  = (69'(pz_r) + (69'sd1 <<< 44)) >>> 45;
    pyr  = (35'(cp2_r) + 35'sd16384) >>> 15;
    px_s = pxr[23:0];
    pz_s = pzr[23:0];
    py_s = pyr[19:0];
    res.pos_x = (px_s > 24'sd32767) ? 16'sh7FFF : (px_s < -24'sd32768) ? 16'sh8000 : px_s[15:0];
    res.pos_z = (pz_s > 24'sd32767) ? 16'sh7FFF : (pz_s < -24'sd32768) ? 16'sh8000 : pz_s[15:0];
    res.pos_y = (py_s > 20'sd32767) ? 16'sh7FFF : (py_s < -20'sd32768) ? 16'sh8000 : py_s[15:0];
    res.tex_u = side_c[CLAT+2].tu;
    res.tex_v = side_c[CLAT+2].tv;
    res.quad_valid = side_c[CLAT+2].quad;
    res.idx_top_left = side_c[CLAT+2].tl;
    res.idx_bottom_left = side_c[CLAT+2].bl;
    res.idx_top_right = side_c[CLAT+2].quad ? side_c[CLAT+2].tl + 21'd1 : '0;
    res.idx_bottom_right = side_c[CLAT+2].quad ? side_c[CLAT+2].bl + 21'd1 : '0;
    res.out_of_range = side_c[CLAT+2].oor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], job_take};
  end

  // Output register: loads when pipeline tail is valid and it is free or drained.
  always_ff @(posedge clk) begin
    if (!rst_n) skid_vld_r <= 1'b0;
    else if (adv) skid_vld_r <= vld_r[LAT-1] || (skid_vld_r && !out_ch.ready);
  end
  always_ff @(posedge clk) begin
    if (adv && vld_r[LAT-1]) skid_r <= res;
  end

  assign out_ch.valid = skid_vld_r;
  assign out_ch.pos_x = skid_r.pos_x;
  assign out_ch.pos_y = skid_r.pos_y;
  assign out_ch.pos_z = skid_r.pos_z;
  assign out_ch.tex_u = skid_r.tex_u;
  assign out_ch.tex_v = skid_r.tex_v;
  assign out_ch.quad_valid = skid_r.quad_valid;
  assign out_ch.idx_top_left = skid_r.idx_top_left;
  assign out_ch.idx_bottom_left = skid_r.idx_bottom_left;
  assign out_ch.idx_top_right = skid_r.idx_top_right;
  assign out_ch.idx_bottom_right = skid_r.idx_bottom_right;
  assign out_ch.out_of_range = skid_r.out_of_range;
endmodule
`default_nettype wire
